>>> hdl/pebrw_pkg.sv
// Shared constants for the base relocation walker.
package pebrw_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_BASE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RELOC_DELTA = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DIR_SIZE = 2'd2;

  localparam logic [1:0] KIND_PATCH = 2'd0;
  localparam logic [1:0] KIND_BAD_TYPE = 2'd1;
  localparam logic [1:0] KIND_MALFORMED = 2'd2;

  localparam logic [2:0] PH_RVA_LO = 3'd0;
  localparam logic [2:0] PH_RVA_HI = 3'd1;
  localparam logic [2:0] PH_SIZE_LO = 3'd2;
  localparam logic [2:0] PH_SIZE_HI = 3'd3;
  localparam logic [2:0] PH_ENTRIES = 3'd4;

  localparam logic [3:0] TYPE_PAD = 4'd0;
  localparam logic [3:0] TYPE_DIR64 = 4'd10;

  localparam logic [31:0] BYTES_SAT = 32'hFFFF_FFFF;
  localparam logic [31:0] BYTES_NEAR_SAT = 32'hFFFF_FFFE;
  localparam logic [31:0] HDR_BYTES = 32'd8;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] addr;
  } result_t;

endpackage

>>> hdl/pe_base_relocation_walker_top.sv
// Base relocation directory walker: header parse, entry decode, patch address output.
//
// Usage:
//   Input channel: one 16-bit directory word per accepted in_valid/!in_stall cycle.
//   Output channel: one word per patch site (kind 0) or error (kind 1, 2) on
//   out_valid/!out_stall. Words that yield nothing produce no output.
//   Configuration: cfg_we with cfg_index (0 image base, 1 delta, 2 dir size)
//   and cfg_data; write only while the block is idle.
//   Throughput: one word per cycle while in_stall is low; the parse state
//   and the 64-bit three-operand address sum sit between the input
//   handshake and the result register.
//   Stall: a two-entry output buffer (result register plus skid register)
//   lets one more word be accepted while a result waits; in_stall rises
//   only when both entries are full.
//   Reset: clears the walk state, the halt flag, the registers and the
//   output buffer; the walker then expects the first header word.
module pe_base_relocation_walker_top
  import pebrw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_dir_word,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic [63:0]        out_patch_address,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [63:0]        cfg_data
);

  logic [63:0] image_base_r;
  logic [63:0] reloc_delta_r;
  logic [31:0] dir_size_r;

  logic [2:0]  phase_r, phase_nxt;
  logic [31:0] page_rva_r, page_rva_nxt;
  logic [31:0] block_bytes_r, block_bytes_nxt;
  logic [30:0] entries_left_r, entries_left_nxt;
  logic [31:0] consumed_r, consumed_nxt;
  logic        halted_r, halted_nxt;

  logic        out_valid_r;
  result_t     out_res_r;
  logic        skid_valid_r;
  result_t     skid_res_r;

  logic        in_acc;
  logic        take;
  logic        res_valid;
  result_t     res;
  logic [31:0] size_full;
  logic [30:0] el_dec;
  logic [3:0]  ent_type;
  logic        out_take;

  assign in_stall = skid_valid_r;
  assign in_acc = in_valid && !in_stall;
  assign take = in_acc && !halted_r && (reloc_delta_r != 64'd0) && (dir_size_r != 32'd0)
                && (consumed_r < dir_size_r);
  assign size_full = {in_dir_word, block_bytes_r[15:0]};
  assign el_dec = (entries_left_r == 31'd0) ? 31'd0 : entries_left_r - 31'd1;
  assign ent_type = in_dir_word[15:12];

  always_comb begin
    phase_nxt = phase_r;
    page_rva_nxt = page_rva_r;
    block_bytes_nxt = block_bytes_r;
    entries_left_nxt = entries_left_r;
    consumed_nxt = consumed_r;
    halted_nxt = halted_r;
    res_valid = 1'b0;
    res.kind = KIND_PATCH;
    res.addr = image_base_r + {32'd0, page_rva_r} + {52'd0, in_dir_word[11:0]};
    if (take) begin
      consumed_nxt = (consumed_r >= BYTES_NEAR_SAT) ? BYTES_SAT : consumed_r + 32'd2;
      case (phase_r)
        PH_RVA_LO: begin
          page_rva_nxt = {page_rva_r[31:16], in_dir_word};
          phase_nxt = PH_RVA_HI;
        end
        PH_RVA_HI: begin
          page_rva_nxt = {in_dir_word, page_rva_r[15:0]};
          phase_nxt = PH_SIZE_LO;
        end
        PH_SIZE_LO: begin
          block_bytes_nxt = {block_bytes_r[31:16], in_dir_word};
          phase_nxt = PH_SIZE_HI;
        end
        PH_SIZE_HI: begin
          block_bytes_nxt = size_full;
          if (size_full < HDR_BYTES || size_full[0]) begin
            halted_nxt = 1'b1;
            phase_nxt = PH_RVA_LO;
            res_valid = 1'b1;
            res.kind = KIND_MALFORMED;
            res.addr = 64'd0;
          end else begin
            entries_left_nxt = size_full[31:1] - 31'd4;
            phase_nxt = (size_full == HDR_BYTES) ? PH_RVA_LO : PH_ENTRIES;
          end
        end
        default: begin
          entries_left_nxt = el_dec;
          if (el_dec == 31'd0) begin
            phase_nxt = PH_RVA_LO;
          end
          if (ent_type == TYPE_DIR64) begin
            res_valid = 1'b1;
          end else if (ent_type != TYPE_PAD) begin
            halted_nxt = 1'b1;
            res_valid = 1'b1;
            res.kind = KIND_BAD_TYPE;
            res.addr = 64'd0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_base_r <= 64'd0;
      reloc_delta_r <= 64'd0;
      dir_size_r <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_BASE: image_base_r <= cfg_data;
        CFG_RELOC_DELTA: reloc_delta_r <= cfg_data;
        CFG_DIR_SIZE: dir_size_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RVA_LO;
      page_rva_r <= 32'd0;
      block_bytes_r <= 32'd0;
      entries_left_r <= 31'd0;
      consumed_r <= 32'd0;
      halted_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      page_rva_r <= page_rva_nxt;
      block_bytes_r <= block_bytes_nxt;
      entries_left_r <= entries_left_nxt;
      consumed_r <= consumed_nxt;
      halted_r <= halted_nxt;
    end
  end

  assign out_take = out_valid_r && !out_stall;

  // hold the result register while stalled; spill into the skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_res_r <= skid_res_r;
      end else if (res_valid) begin
        out_res_r <= res;
      end
    end else if (res_valid) begin
      skid_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind = out_res_r.kind;
  assign out_patch_address = out_res_r.addr;

endmodule
